### design/gre_header_parser_assert.svh
// Assertion macros shared by the GRE header parser modules.
`ifndef GRE_HEADER_PARSER_ASSERT_SVH
`define GRE_HEADER_PARSER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define GHP_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that implies another in the same cycle.
`define GHP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies another in the following cycle.
`define GHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ghp_pkg.sv
// Types and constants shared by the GRE header parser modules.
package ghp_pkg;

    // Status codes reported on the final byte of a packet.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_BAD_VER   = 2'd2;

    // Byte offsets of the fixed header words.
    localparam logic [15:0] POS_FLAG_HI = 16'd0;
    localparam logic [15:0] POS_FLAG_LO = 16'd1;
    localparam logic [15:0] POS_TYPE_HI = 16'd2;
    localparam logic [15:0] POS_TYPE_LO = 16'd3;

    // Flag word bits.
    localparam int FLAG_CHECKSUM = 15;
    localparam int FLAG_ROUTING  = 14;
    localparam int FLAG_KEY      = 13;
    localparam int FLAG_SEQUENCE = 12;

    // Size of the base header and of each optional field.
    localparam logic [15:0] BASE_HDR_LEN = 16'd4;
    localparam logic [15:0] OPT_FIELD_LEN = 16'd4;

    // One parsed byte with its side information.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_payload;
        logic        end_of_packet;
        logic [1:0]  status;
        logic [15:0] protocol_type;
        logic [15:0] header_length;
    } result_t;

endpackage

### design/ghp_hdr_core.sv
// Parse state of the GRE header and the per-byte result logic.
module ghp_hdr_core #(
    parameter int MAX_PACKET_LEN = 65535
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             last,
    output ghp_pkg::result_t result
);

`include "gre_header_parser_assert.svh"

    localparam logic [15:0] MaxLen = 16'(MAX_PACKET_LEN);

    logic [15:0] byte_position_reg, byte_position_next;
    logic [15:0] flag_word_reg, flag_word_next;
    logic [15:0] type_word_reg, type_word_next;
    logic [15:0] next_boundary_reg, next_boundary_next;
    logic        walking_routes_reg, walking_routes_next;
    logic        header_done_reg, header_done_next;
    logic        version_bad_reg, version_bad_next;

    logic        in_parse;
    logic [15:0] opt_len;
    logic [16:0] entry_end;
    logic        at_len_byte;
    logic [1:0]  status;

    // Header field capture and route chain walk for one byte.
    always_comb begin
        in_parse            = byte_position_reg < MaxLen;
        byte_position_next  = byte_position_reg;
        flag_word_next      = flag_word_reg;
        type_word_next      = type_word_reg;
        next_boundary_next  = next_boundary_reg;
        walking_routes_next = walking_routes_reg;
        header_done_next    = header_done_reg;
        version_bad_next    = version_bad_reg;

        opt_len = ghp_pkg::BASE_HDR_LEN
            + ((flag_word_reg[ghp_pkg::FLAG_CHECKSUM] || flag_word_reg[ghp_pkg::FLAG_ROUTING])
                ? ghp_pkg::OPT_FIELD_LEN : 16'd0)
            + (flag_word_reg[ghp_pkg::FLAG_KEY] ? ghp_pkg::OPT_FIELD_LEN : 16'd0)
            + (flag_word_reg[ghp_pkg::FLAG_SEQUENCE] ? ghp_pkg::OPT_FIELD_LEN : 16'd0);
        entry_end   = {1'b0, next_boundary_reg} + 17'd4 + {9'd0, data_byte};
        at_len_byte = {1'b0, byte_position_reg} == ({1'b0, next_boundary_reg} + 17'd3);

        if (in_parse) begin
            priority if (byte_position_reg == ghp_pkg::POS_FLAG_HI) begin
                flag_word_next = {data_byte, 8'h00};
            end else if (byte_position_reg == ghp_pkg::POS_FLAG_LO) begin
                flag_word_next   = {flag_word_reg[15:8], data_byte};
                version_bad_next = data_byte[1:0] != 2'b00;
            end else if (byte_position_reg == ghp_pkg::POS_TYPE_HI) begin
                type_word_next = {data_byte, 8'h00};
            end else if (byte_position_reg == ghp_pkg::POS_TYPE_LO) begin
                type_word_next      = {type_word_reg[15:8], data_byte};
                next_boundary_next  = opt_len;
                walking_routes_next = flag_word_reg[ghp_pkg::FLAG_ROUTING];
            end else if (walking_routes_reg && at_len_byte) begin
                // Length byte of a source route entry: move to the next entry.
                if (entry_end > {1'b0, MaxLen}) begin
                    next_boundary_next = MaxLen;
                end else begin
                    next_boundary_next = entry_end[15:0];
                    if (data_byte == 8'd0) begin
                        walking_routes_next = 1'b0;
                    end
                end
            end else begin
                flag_word_next = flag_word_reg;
            end

            // The header ends with this byte.
            if (byte_position_reg >= ghp_pkg::POS_TYPE_LO && !walking_routes_next
                && ({1'b0, byte_position_reg} + 17'd1) == {1'b0, next_boundary_next}) begin
                header_done_next = 1'b1;
            end
            byte_position_next = byte_position_reg + 16'd1;
        end
    end

    // Status on the final byte.
    always_comb begin
        priority if (!last) begin
            status = ghp_pkg::STATUS_OK;
        end else if (byte_position_reg < ghp_pkg::POS_TYPE_LO) begin
            status = ghp_pkg::STATUS_TRUNCATED;
        end else if (version_bad_next) begin
            status = ghp_pkg::STATUS_BAD_VER;
        end else if (!header_done_next) begin
            status = ghp_pkg::STATUS_TRUNCATED;
        end else begin
            status = ghp_pkg::STATUS_OK;
        end
    end

    // Result fields for this byte.
    always_comb begin
        result.out_byte      = data_byte;
        result.is_payload    = header_done_reg && !version_bad_reg;
        result.end_of_packet = last;
        result.status        = status;
        result.protocol_type = (byte_position_reg >= ghp_pkg::POS_TYPE_LO)
                               ? type_word_next : 16'd0;
        result.header_length = header_done_next ? next_boundary_next : 16'd0;
    end

    // Parse state; returns to its reset values after the final byte.
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && last)) begin
            byte_position_reg  <= '0;
            flag_word_reg      <= '0;
            type_word_reg      <= '0;
            next_boundary_reg  <= ghp_pkg::BASE_HDR_LEN;
            walking_routes_reg <= 1'b0;
            header_done_reg    <= 1'b0;
            version_bad_reg    <= 1'b0;
        end else if (accept) begin
            byte_position_reg  <= byte_position_next;
            flag_word_reg      <= flag_word_next;
            type_word_reg      <= type_word_next;
            next_boundary_reg  <= next_boundary_next;
            walking_routes_reg <= walking_routes_next;
            header_done_reg    <= header_done_next;
            version_bad_reg    <= version_bad_next;
        end
    end

    `GHP_ASSERT_HOLDS(a_walk_excludes_done, !(walking_routes_reg && header_done_reg),
        "route walk active after header completed")
    `GHP_ASSERT_HOLDS(a_position_bounded, byte_position_reg <= MaxLen,
        "byte position beyond maximum packet length")
    `GHP_ASSERT_NEXT(a_last_clears_state, accept && last,
        byte_position_reg == 16'd0 && !header_done_reg && !walking_routes_reg,
        "parse state not cleared after final byte")

endmodule

### design/ghp_out_skid.sv
// Output register with a skid stage for the parsed byte stream.
module ghp_out_skid (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  ghp_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output ghp_pkg::result_t out_data
);

`include "gre_header_parser_assert.svh"

    ghp_pkg::result_t out_data_reg;
    ghp_pkg::result_t skid_data_reg;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             in_ready_reg;
    logic             in_xfer;
    logic             load_out_from_in;
    logic             load_out_from_skid;
    logic             load_skid;

    assign in_xfer = in_valid && in_ready_reg;

    // Decide where an accepted transfer lands and when the skid drains.
    always_comb begin
        load_out_from_skid = skid_valid_reg && out_ready;
        load_out_from_in   = in_xfer && (!out_valid_reg || out_ready);
        load_skid          = in_xfer && out_valid_reg && !out_ready;
        out_valid_next     = out_valid_reg;
        skid_valid_next    = skid_valid_reg;
        if (load_out_from_skid) begin
            skid_valid_next = 1'b0;
        end else if (load_out_from_in) begin
            out_valid_next = 1'b1;
        end else if (load_skid) begin
            skid_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            in_ready_reg   <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            in_ready_reg   <= !skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (load_out_from_skid) begin
            out_data_reg <= skid_data_reg;
        end else if (load_out_from_in) begin
            out_data_reg <= in_data;
        end
        if (load_skid) begin
            skid_data_reg <= in_data;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `GHP_ASSERT_IMPLIES(a_skid_needs_out, skid_valid_reg, out_valid_reg,
        "skid stage full while output register empty")
    `GHP_ASSERT_NEXT(a_stall_fills_skid, in_xfer && out_valid_reg && !out_ready,
        skid_valid_reg, "stalled transfer not held in skid stage")

endmodule

### design/gre_header_parser.sv
// Each input byte transfer's result is registered in the output register, or held in the
// skid stage while m_tready holds back the results ahead of it.
// Throughput: one byte per cycle while s_tready stays high; the per-byte parse is a single compare-and-add stage.
// A two-entry output buffer (output register plus skid) keeps s_tready registered.
// Reset (aresetn low, synchronous) clears the parse state and empties the buffer.
// Parse state also returns to its reset values after each byte marked by s_tlast.
module gre_header_parser #(
    parameter int MAX_PACKET_LEN = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] out_byte, [9:8] status, [25:10] protocol_type,
                                   // [41:26] header_length, [47:42] zero
    output logic        m_tuser,   // [0] is_payload
    output logic        m_tlast
);

    ghp_pkg::result_t core_result;
    ghp_pkg::result_t out_result;
    logic             in_transfer;

    assign in_transfer = s_tvalid && s_tready;

    // Header parser.
    ghp_hdr_core #(
        .MAX_PACKET_LEN(MAX_PACKET_LEN)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (in_transfer),
        .data_byte (s_tdata),
        .last      (s_tlast),
        .result    (core_result)
    );

    // Output buffering.
    ghp_out_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // Pack the result onto the master side.
    assign m_tdata = {6'd0, out_result.header_length, out_result.protocol_type,
                      out_result.status, out_result.out_byte};
    assign m_tuser = out_result.is_payload;
    assign m_tlast = out_result.end_of_packet;

endmodule

### dv/gre_header_parser_tb.sv
// Self-checking testbench for the GRE header parser: directed and random packets, scoreboard.
module gre_header_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN         = 65535;
    localparam int ROUTE_ENTRY_HDR = 4;      // Address family, SRE offset, SRE length.
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_BYTES    = 1070;
    localparam int QUIET_TAIL      = 150;

    // Mirrors the parse state and keeps the predicted results in arrival order.
    class gre_byte_scoreboard;
        int unsigned      position;
        int unsigned      boundary;
        logic [15:0]      flags;
        logic [15:0]      ptype;
        bit               walking;
        bit               hdr_done;
        bit               ver_bad;
        ghp_pkg::result_t pending_bytes[$];
        int               mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            position = 0;
            boundary = ghp_pkg::BASE_HDR_LEN;
            flags    = '0;
            ptype    = '0;
            walking  = 1'b0;
            hdr_done = 1'b0;
            ver_bad  = 1'b0;
        endfunction

        // Predict the result for one accepted packet byte.
        function void take_packet_byte(logic [7:0] b, logic last);
            int unsigned      pos;
            int unsigned      route_end;
            ghp_pkg::result_t r;
            pos = position;
            r = '0;
            r.out_byte      = b;
            r.is_payload    = hdr_done && !ver_bad;
            r.end_of_packet = last;

            if (pos < MAX_LEN) begin
                if (pos == ghp_pkg::POS_FLAG_HI) begin
                    flags = {b, 8'h00};
                end else if (pos == ghp_pkg::POS_FLAG_LO) begin
                    flags[7:0] = b;
                    ver_bad = |flags[1:0];
                end else if (pos == ghp_pkg::POS_TYPE_HI) begin
                    ptype = {b, 8'h00};
                end else if (pos == ghp_pkg::POS_TYPE_LO) begin
                    ptype[7:0] = b;
                    boundary = ghp_pkg::BASE_HDR_LEN;
                    if (flags[ghp_pkg::FLAG_CHECKSUM] || flags[ghp_pkg::FLAG_ROUTING])
                        boundary += ghp_pkg::OPT_FIELD_LEN;
                    if (flags[ghp_pkg::FLAG_KEY])
                        boundary += ghp_pkg::OPT_FIELD_LEN;
                    if (flags[ghp_pkg::FLAG_SEQUENCE])
                        boundary += ghp_pkg::OPT_FIELD_LEN;
                    walking = flags[ghp_pkg::FLAG_ROUTING];
                end else if (walking && pos == boundary + ROUTE_ENTRY_HDR - 1) begin
                    // The length byte of a source route entry moves the boundary on.
                    route_end = boundary + ROUTE_ENTRY_HDR + b;
                    if (route_end > MAX_LEN) begin
                        boundary = MAX_LEN;
                    end else begin
                        boundary = route_end;
                        if (b == 8'h00)
                            walking = 1'b0;
                    end
                end
                if (pos >= ghp_pkg::POS_TYPE_LO && !walking && pos + 1 == boundary)
                    hdr_done = 1'b1;
                position = pos + 1;
            end

            if (last) begin
                if (pos < ghp_pkg::POS_TYPE_LO)
                    r.status = ghp_pkg::STATUS_TRUNCATED;
                else if (ver_bad)
                    r.status = ghp_pkg::STATUS_BAD_VER;
                else if (!hdr_done)
                    r.status = ghp_pkg::STATUS_TRUNCATED;
                else
                    r.status = ghp_pkg::STATUS_OK;
            end
            r.protocol_type = (pos >= ghp_pkg::POS_TYPE_LO) ? ptype : 16'h0000;
            r.header_length = hdr_done ? 16'(boundary) : 16'h0000;
            pending_bytes.push_back(r);
            if (last)
                restart();
        endfunction

        // Compare one result transfer with the oldest prediction.
        function void check_parsed_byte(ghp_pkg::result_t got);
            ghp_pkg::result_t want;
            if (pending_bytes.size() == 0) begin
                $error("result transfer with nothing predicted, out_byte %0h", got.out_byte);
                mismatches++;
                return;
            end
            want = pending_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.is_payload !== want.is_payload) begin
                $error("is_payload: expected %0b, actual %0b", want.is_payload, got.is_payload);
                mismatches++;
            end
            if (got.end_of_packet !== want.end_of_packet) begin
                $error("end_of_packet: expected %0b, actual %0b",
                       want.end_of_packet, got.end_of_packet);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.protocol_type !== want.protocol_type) begin
                $error("protocol_type: expected %0h, actual %0h",
                       want.protocol_type, got.protocol_type);
                mismatches++;
            end
            if (got.header_length !== want.header_length) begin
                $error("header_length: expected %0d, actual %0d",
                       want.header_length, got.header_length);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // [7:0] data_byte
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;            // [7:0] out_byte, [9:8] status, [25:10] protocol_type,
                                     // [41:26] header_length, [47:42] zero
    logic        m_tuser;            // [0] is_payload
    logic        m_tlast;

    gre_byte_scoreboard sb = new();
    logic [7:0] pkt[$];
    bit         idle_mode = 1'b1;
    bit         hold_req = 1'b0;
    int         quiet_cycles = 0;

    gre_header_parser #(
        .MAX_PACKET_LEN(MAX_LEN)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Offer one byte, with an occasional gap first, and wait for its transfer.
    task automatic send_byte(logic [7:0] b, logic last);
        if (idle_mode && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.take_packet_byte(b, last);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    function automatic void put_fill(int n);
        repeat (n) pkt.push_back(8'($urandom));
    endfunction

    function automatic void put_header(logic [15:0] flags, logic [15:0] ptype);
        pkt.push_back(flags[15:8]);
        pkt.push_back(flags[7:0]);
        pkt.push_back(ptype[15:8]);
        pkt.push_back(ptype[7:0]);
    endfunction

    // One source route entry; a length of zero ends the chain.
    function automatic void put_route(logic [7:0] len);
        put_fill(ROUTE_ENTRY_HDR - 1);
        pkt.push_back(len);
        put_fill(len);
    endfunction

    // Mostly well-formed packets with random content, plus noise, bad versions and cut-offs.
    function automatic void build_random_packet();
        int          kind;
        int          cut;
        logic [15:0] flags;
        kind = $urandom_range(0, 19);
        pkt.delete();
        if (kind == 0) begin
            put_fill($urandom_range(1, 24));
            return;
        end
        flags = 16'($urandom);
        if (kind != 1)
            flags[1:0] = 2'b00;
        put_header(flags, 16'($urandom));
        if (flags[ghp_pkg::FLAG_CHECKSUM] || flags[ghp_pkg::FLAG_ROUTING])
            put_fill(ghp_pkg::OPT_FIELD_LEN);
        if (flags[ghp_pkg::FLAG_KEY])
            put_fill(ghp_pkg::OPT_FIELD_LEN);
        if (flags[ghp_pkg::FLAG_SEQUENCE])
            put_fill(ghp_pkg::OPT_FIELD_LEN);
        if (flags[ghp_pkg::FLAG_ROUTING]) begin
            repeat ($urandom_range(0, 3))
                put_route(8'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 255)
                                                         : $urandom_range(1, 12)));
            put_route(8'h00);
        end
        put_fill($urandom_range(0, 12));
        if (kind == 2 || kind == 3) begin
            cut = $urandom_range(1, pkt.size());
            while (pkt.size() > cut)
                void'(pkt.pop_back());
        end
    endfunction

    // Receiver: random stall bursts, and one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (idle_mode && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check every result transfer.
    always @(posedge aclk) begin : collect
        ghp_pkg::result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.out_byte      = m_tdata[7:0];
            got.status        = m_tdata[9:8];
            got.protocol_type = m_tdata[25:10];
            got.header_length = m_tdata[41:26];
            got.is_payload    = m_tuser;
            got.end_of_packet = m_tlast;
            sb.check_parsed_byte(got);
        end
    end

    // Stop the run if no transfer happens for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Main sequence: reset, directed packets, random packets, drain.
    initial begin
        int sent;
        int pkt_count;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Packets shorter than the base header, one with the version bits set.
        pkt = '{8'hFF};
        send_packet();
        pkt = '{8'h00, 8'h03};
        send_packet();
        pkt = '{8'h00, 8'h00, 8'h08};
        send_packet();

        // Base header only, then a bad version followed by data.
        pkt.delete();
        put_header(16'h0000, 16'h0800);
        send_packet();
        pkt.delete();
        put_header(16'h0001, 16'h86DD);
        put_fill(3);
        send_packet();

        // Checksum, key and sequence together.
        pkt.delete();
        put_header(16'hB000, 16'h6558);
        put_fill(3 * ghp_pkg::OPT_FIELD_LEN + 4);
        send_packet();

        // Routing with one entry and the null entry.
        pkt.delete();
        put_header(16'h4000, 16'h0800);
        put_fill(ghp_pkg::OPT_FIELD_LEN);
        put_route(8'd2);
        put_route(8'd0);
        put_fill(3);
        send_packet();

        // Header cut short inside the key field.
        pkt.delete();
        put_header(16'h2000, 16'hFFFF);
        put_fill(2);
        send_packet();

        // Bad version with an optional field; the length is still reported.
        pkt.delete();
        put_header(16'h8003, 16'h0000);
        put_fill(ghp_pkg::OPT_FIELD_LEN + 1);
        send_packet();

        // Header that ends exactly on the last byte.
        pkt.delete();
        put_header(16'h1000, 16'h0001);
        put_fill(ghp_pkg::OPT_FIELD_LEN);
        send_packet();

        // Random packets; the tail runs without any idling.
        sent = 0;
        pkt_count = 0;
        while (sent < RANDOM_BYTES) begin
            idle_mode = (sent < RANDOM_BYTES - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if (pkt_count == 5)
                hold_req = 1'b1;
            build_random_packet();
            send_packet();
            sent += pkt.size();
            pkt_count++;
        end
        s_tvalid <= 1'b0;

        while (sb.pending_bytes.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_bytes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### gre_header_parser.f
+incdir+design
design/ghp_pkg.sv
design/ghp_hdr_core.sv
design/ghp_out_skid.sv
design/gre_header_parser.sv
dv/gre_header_parser_tb.sv
